>>> hw/rtl/rjs_pkg.sv
// ----------------------------------------------------------------------------
// rjs_pkg
// Shared types and constants for the recency job scheduler.
// ----------------------------------------------------------------------------
package rjs_pkg;

  localparam int JOB_W = 4;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_UNSET = 2'd1,
    OP_EXEC  = 2'd2,
    OP_PEEK  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic run;
  } ctl_cmd_t;

endpackage

>>> hw/rtl/rjs_ctrl.sv
// ----------------------------------------------------------------------------
// rjs_ctrl
// Controller: accepts a command beat, runs one update of the datapath and
// raises the result strobe in the following cycle.
// ----------------------------------------------------------------------------
module rjs_ctrl
  import rjs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output ctl_cmd_t cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.run;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.run    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/rjs_datapath.sv
// ----------------------------------------------------------------------------
// rjs_datapath
// Compare-and-shift cell stack of pending jobs, top of stack in cell zero,
// with the command capture and result registers.
// ----------------------------------------------------------------------------
module rjs_datapath
  import rjs_pkg::*;
#(
  parameter int NUM_JOBS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_cmd_t         cmd,
  input  logic [1:0]       op,
  input  logic [JOB_W-1:0] job_index,
  output logic             top_valid,
  output logic [JOB_W-1:0] top_job,
  output logic             was_pending,
  output logic             any_pending,
  output logic             empty_error
);

  localparam int CW = $clog2(NUM_JOBS + 1);
  localparam int PW = $clog2(NUM_JOBS);

  op_t              op_q;
  logic [JOB_W-1:0] job_q;
  logic [JOB_W-1:0] cells [NUM_JOBS];
  logic [JOB_W-1:0] cells_next [NUM_JOBS];
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [NUM_JOBS-1:0] match;
  logic [PW-1:0]    pos;
  logic             in_range;
  logic             hit;
  logic             empty;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op_t'(op);
      job_q <= job_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.run) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      for (int i = 0; i < NUM_JOBS; i++) begin
        cells[i] <= cells_next[i];
      end
      top_valid   <= !empty && (op_q == OP_EXEC || op_q == OP_PEEK);
      top_job     <= (!empty && (op_q == OP_EXEC || op_q == OP_PEEK)) ? cells[0] : '0;
      was_pending <= (op_q == OP_SET || op_q == OP_UNSET) ? hit : !empty;
      any_pending <= (count_next != '0);
      empty_error <= empty && (op_q == OP_EXEC);
    end
  end

  always_comb begin
    in_range = (32'(job_q) < NUM_JOBS);
    empty    = (count == '0);
    pos      = '0;
    for (int i = 0; i < NUM_JOBS; i++) begin
      match[i] = in_range && (CW'(i) < count) && (cells[i] == job_q);
      if (match[i]) begin
        pos = pos | PW'(i);
      end
    end
    hit = |match;
  end

  always_comb begin
    count_next = count;
    for (int i = 0; i < NUM_JOBS; i++) begin
      cells_next[i] = cells[i];
    end
    case (op_q)
      OP_SET: begin
        if (in_range && hit) begin
          for (int i = 0; i < NUM_JOBS; i++) begin
            if (PW'(i) <= pos) begin
              cells_next[i] = (i == 0) ? job_q : cells[(i == 0) ? 0 : i - 1];
            end
          end
        end else if (in_range && (count < CW'(NUM_JOBS))) begin
          for (int i = 0; i < NUM_JOBS; i++) begin
            cells_next[i] = (i == 0) ? job_q : cells[(i == 0) ? 0 : i - 1];
          end
          count_next = count + CW'(1);
        end
      end
      OP_UNSET: begin
        if (hit) begin
          for (int i = 0; i < NUM_JOBS - 1; i++) begin
            if (PW'(i) >= pos) begin
              cells_next[i] = cells[i + 1];
            end
          end
          count_next = count - CW'(1);
        end
      end
      OP_EXEC: begin
        if (!empty) begin
          for (int i = 0; i < NUM_JOBS - 1; i++) begin
            cells_next[i] = cells[i + 1];
          end
          count_next = count - CW'(1);
        end
      end
      OP_PEEK: begin
        count_next = count;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

endmodule

>>> hw/rtl/recency_job_scheduler.sv
// ----------------------------------------------------------------------------
// recency_job_scheduler
// Move-to-front stack of pending jobs: set, unset, execute and peek.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Signals
//  command   start high, busy low op, job_index
//  result    done, one cycle      top_valid, top_job, was_pending,
//                                 any_pending, empty_error
//
//  Each command beat is captured first, then the cell stack compares and
//  shifts. The result beat is shown in the cycle after the update, while
//  busy is already low for the next command.
//  Reset empties the stack at once; the cell contents are not cleared.
//  The result receiver cannot stall the block.
// ----------------------------------------------------------------------------
module recency_job_scheduler
  import rjs_pkg::*;
#(
  parameter int NUM_JOBS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       op,
  input  logic [JOB_W-1:0] job_index,
  output logic             done,
  output logic             top_valid,
  output logic [JOB_W-1:0] top_job,
  output logic             was_pending,
  output logic             any_pending,
  output logic             empty_error
);

  ctl_cmd_t cmd;

  rjs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  rjs_datapath #(
    .NUM_JOBS (NUM_JOBS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .job_index   (job_index),
    .top_valid   (top_valid),
    .top_job     (top_job),
    .was_pending (was_pending),
    .any_pending (any_pending),
    .empty_error (empty_error)
  );

endmodule

>>> hw/rtl/rjs_checker.sv
// ----------------------------------------------------------------------------
// rjs_checker
// Port-level checks on the recency job scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module rjs_checker
  import rjs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             top_valid,
  input logic [JOB_W-1:0] top_job,
  input logic             was_pending,
  input logic             any_pending,
  input logic             empty_error
);

  // A command beat is answered by a result beat once the run state is through.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result beat missing after command beat");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("block not busy after command beat");

  a_error_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(top_valid && empty_error))
    else $error("top valid and empty error together");

  a_error_means_empty: assert property (@(posedge clk) disable iff (rst)
    done && empty_error |-> !any_pending && !was_pending && top_job == '0)
    else $error("empty error while jobs pending");

  a_top_implies_pending: assert property (@(posedge clk) disable iff (rst)
    done && top_valid |-> was_pending)
    else $error("top job reported without pending flag");

endmodule

bind recency_job_scheduler rjs_checker u_rjs_checker (.*);

>>> bench/recency_job_scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recency_job_scheduler_checker
// Watches the command and result channels of the recency job scheduler. It
// keeps its own move-to-front job stack, predicts each result beat from
// every accepted command beat and compares the result beats field by field.
// ----------------------------------------------------------------------------
module recency_job_scheduler_checker
  import rjs_pkg::*;
#(
  parameter int NUM_JOBS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       op,
  input  logic [JOB_W-1:0] job_index,
  input  logic             done,
  input  logic             top_valid,
  input  logic [JOB_W-1:0] top_job,
  input  logic             was_pending,
  input  logic             any_pending,
  input  logic             empty_error,
  output int               fail_count,
  output int               outstanding,
  output int               results_checked,
  output int               empty_errors,
  output int               peak_depth
);

  typedef struct packed {
    logic             top_valid;
    logic [JOB_W-1:0] top_job;
    logic             was_pending;
    logic             any_pending;
    logic             empty_error;
  } job_result_t;

  logic             job_pending [NUM_JOBS];
  logic [JOB_W-1:0] job_stack [NUM_JOBS];
  int               depth;
  job_result_t      expected_results [$];

  initial begin
    fail_count      = 0;
    outstanding     = 0;
    results_checked = 0;
    empty_errors    = 0;
    peak_depth      = 0;
    depth           = 0;
  end

  function automatic void drop_job(logic [JOB_W-1:0] job);
    int pos = -1;
    for (int i = 0; i < depth; i++) begin
      if (pos < 0 && job_stack[i] == job) begin
        pos = i;
      end
    end
    if (pos < 0) begin
      return;
    end
    for (int i = pos; i < depth - 1; i++) begin
      job_stack[i] = job_stack[i + 1];
    end
    depth--;
  endfunction

  function automatic job_result_t schedule_step(op_t cmd, logic [JOB_W-1:0] job);
    job_result_t r;
    r = '0;
    case (cmd)
      OP_SET, OP_UNSET: begin
        if (job < NUM_JOBS) begin
          r.was_pending = job_pending[job];
          if (job_pending[job]) begin
            drop_job(job);
          end
          if (cmd == OP_SET && depth < NUM_JOBS) begin
            job_stack[depth] = job;
            depth++;
            job_pending[job] = 1'b1;
          end else begin
            job_pending[job] = 1'b0;
          end
        end
      end
      default: begin
        if (depth == 0) begin
          r.empty_error = (cmd == OP_EXEC);
        end else begin
          r.top_job     = job_stack[depth - 1];
          r.top_valid   = 1'b1;
          r.was_pending = 1'b1;
          if (cmd == OP_EXEC) begin
            depth--;
            job_pending[r.top_job] = 1'b0;
          end
        end
      end
    endcase
    r.any_pending = (depth != 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [JOB_W-1:0] want,
                                      logic [JOB_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    job_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_JOBS; i++) begin
        job_pending[i] = 1'b0;
      end
      depth = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("Result beat arrived with no command beat waiting for it.");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("top_valid", JOB_W'(want.top_valid), JOB_W'(top_valid));
          check_field("top_job", want.top_job, top_job);
          check_field("was_pending", JOB_W'(want.was_pending), JOB_W'(was_pending));
          check_field("any_pending", JOB_W'(want.any_pending), JOB_W'(any_pending));
          check_field("empty_error", JOB_W'(want.empty_error), JOB_W'(empty_error));
          results_checked++;
        end
      end
      if (start && !busy) begin
        want = schedule_step(op_t'(op), job_index);
        expected_results.push_back(want);
        if (want.empty_error) begin
          empty_errors++;
        end
        if (depth > peak_depth) begin
          peak_depth = depth;
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the recency job scheduler. A short directed sequence covers
// the empty stack, move-to-front and removal from the bottom; random bursts
// then fill and drain the stack under varying sender gaps, while the checker
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import rjs_pkg::*;

  localparam int NUM_JOBS    = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       op = OP_SET;
  logic [JOB_W-1:0] job_index = '0;
  logic             done;
  logic             top_valid;
  logic [JOB_W-1:0] top_job;
  logic             was_pending;
  logic             any_pending;
  logic             empty_error;

  int fail_count;
  int outstanding;
  int results_checked;
  int empty_errors;
  int peak_depth;

  int cycles = 0;
  int idle_pct = 0;
  int op_counts [4] = '{default: 0};

  always #5 clk = ~clk;

  recency_job_scheduler #(
    .NUM_JOBS(NUM_JOBS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .job_index  (job_index),
    .done       (done),
    .top_valid  (top_valid),
    .top_job    (top_job),
    .was_pending(was_pending),
    .any_pending(any_pending),
    .empty_error(empty_error)
  );

  recency_job_scheduler_checker #(
    .NUM_JOBS(NUM_JOBS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .job_index      (job_index),
    .done           (done),
    .top_valid      (top_valid),
    .top_job        (top_job),
    .was_pending    (was_pending),
    .any_pending    (any_pending),
    .empty_error    (empty_error),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .empty_errors   (empty_errors),
    .peak_depth     (peak_depth)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("recency_job_scheduler regression: fail");
      $finish;
    end
  end

  task automatic issue(op_t cmd, logic [JOB_W-1:0] job);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start     = 1'b1;
    op        = cmd;
    job_index = job;
    do @(posedge clk); while (busy);
    op_counts[cmd]++;
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic random_command(int mode);
    int   roll;
    op_t  cmd;
    roll = $urandom_range(99);
    case (mode)
      0: cmd = roll < 70 ? OP_SET : roll < 80 ? OP_UNSET : roll < 90 ? OP_EXEC : OP_PEEK;
      1: cmd = roll < 15 ? OP_SET : roll < 30 ? OP_UNSET : roll < 80 ? OP_EXEC : OP_PEEK;
      default: cmd = roll < 40 ? OP_SET : roll < 60 ? OP_UNSET : roll < 85 ? OP_EXEC : OP_PEEK;
    endcase
    issue(cmd, JOB_W'($urandom_range(NUM_JOBS - 1)));
  endtask

  initial begin
    int phase_idle [3] = '{16, 55, 0};
    repeat (3) @(negedge clk);
    rst = 1'b0;

    issue(OP_EXEC, 4'd15);
    issue(OP_PEEK, 4'd0);
    issue(OP_UNSET, 4'd0);
    issue(OP_SET, 4'd0);
    issue(OP_SET, 4'd15);
    issue(OP_SET, 4'd10);
    issue(OP_PEEK, 4'd15);
    issue(OP_SET, 4'd0);
    issue(OP_PEEK, 4'd0);
    issue(OP_UNSET, 4'd15);
    issue(OP_UNSET, 4'd15);
    issue(OP_EXEC, 4'd0);
    issue(OP_EXEC, 4'd15);
    issue(OP_EXEC, 4'd0);
    issue(OP_SET, 4'd15);
    issue(OP_SET, 4'd5);
    issue(OP_EXEC, 4'd7);
    issue(OP_PEEK, 4'd8);
    issue(OP_UNSET, 4'd15);
    issue(OP_PEEK, 4'd15);
    issue(OP_EXEC, 4'd15);
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = phase_idle[phase];
      for (int burst = 0; burst < 13; burst++) begin
        int mode;
        mode = $urandom_range(2);
        repeat (40) random_command(mode);
        if ($urandom_range(3) == 0) begin
          settle();
        end
      end
      settle();
    end

    repeat (8) @(negedge clk);
    $display("Ran %0d commands (%0d set, %0d unset, %0d execute, %0d peek); %0d results checked.",
             op_counts[0] + op_counts[1] + op_counts[2] + op_counts[3],
             op_counts[OP_SET], op_counts[OP_UNSET], op_counts[OP_EXEC], op_counts[OP_PEEK],
             results_checked);
    $display("Stack reached a depth of %0d of %0d jobs; %0d executes found it empty.",
             peak_depth, NUM_JOBS, empty_errors);
    if (fail_count == 0) begin
      $display("recency_job_scheduler regression: pass");
    end else begin
      $display("recency_job_scheduler regression: fail");
    end
    $finish;
  end

endmodule

>>> recency_job_scheduler.f
hw/rtl/rjs_pkg.sv
hw/rtl/rjs_ctrl.sv
hw/rtl/rjs_datapath.sv
hw/rtl/recency_job_scheduler.sv
hw/rtl/rjs_checker.sv
bench/recency_job_scheduler_checker.sv
bench/testbench.sv
